[design/pmf_pkg.sv]
`default_nettype none

package pmf_pkg;

  localparam int NUM_PORTS  = 16;
  // Ports beyond the reach of a 4-bit port field never exist.
  localparam int PORT_LIMIT = (NUM_PORTS < 16) ? NUM_PORTS : 16;

  localparam int PORT_W    = 4;
  localparam int ID_W      = 16;
  localparam int ROW_W     = 16;
  localparam int ADDR_W    = 16;
  localparam int ROW_COUNT = 65536;

  localparam logic [PORT_W:0] PORT_LIMIT_V = (PORT_W + 1)'(PORT_LIMIT);
  localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(ROW_COUNT - 1);

  // Request kinds on tuser
  localparam logic [1:0] REQ_CONNECT    = 2'd0;
  localparam logic [1:0] REQ_DISCONNECT = 2'd1;
  localparam logic [1:0] REQ_CLEAR      = 2'd2;
  localparam logic [1:0] REQ_FRAME      = 2'd3;

  localparam logic [ID_W-1:0] HDR_SUBSCRIBE   = 16'hFFFF;
  localparam logic [ID_W-1:0] HDR_UNSUBSCRIBE = 16'hFFFE;
  localparam logic [ID_W-1:0] ID_BROADCAST    = 16'h0000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_CONNECT,
    OP_DISCONNECT,
    OP_CLEAR,
    OP_SUBSCRIBE,
    OP_UNSUBSCRIBE,
    OP_DISPATCH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PORT_W-1:0] port;
    logic [ID_W-1:0]   id;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   message_id;
    logic [PORT_W-1:0] from_port;
    logic [PORT_W-1:0] dest_port;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

[design/pmf_front.sv]
`default_nettype none

module pmf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [39:0]   s_tdata,
  input  wire logic [1:0]    s_tuser,
  input  wire logic          init_busy,
  output logic               cmd_valid,
  output pmf_pkg::cmd_t      cmd,
  input  wire logic          cmd_ready
);

  logic [pmf_pkg::PORT_W-1:0] src;
  logic [pmf_pkg::ID_W-1:0]   hdr;
  logic [pmf_pkg::ID_W-1:0]   opnd;
  logic                       port_ok;
  logic                       keep;
  pmf_pkg::cmd_t              cmd_next;

  assign src  = s_tdata[3:0];
  assign hdr  = s_tdata[19:4];
  assign opnd = s_tdata[35:20];

  assign port_ok  = {1'b0, src} < pmf_pkg::PORT_LIMIT_V;
  // drop requests from absent ports; clear all is taken from anyone
  assign keep     = (s_tuser == pmf_pkg::REQ_CLEAR) || port_ok;
  assign s_tready = !init_busy && (!cmd_valid || cmd_ready);

  always_comb begin
    cmd_next.port = src;
    cmd_next.id   = hdr;
    cmd_next.op   = pmf_pkg::OP_DISPATCH;
    unique case (s_tuser)
      pmf_pkg::REQ_CONNECT:    cmd_next.op = pmf_pkg::OP_CONNECT;
      pmf_pkg::REQ_DISCONNECT: cmd_next.op = pmf_pkg::OP_DISCONNECT;
      pmf_pkg::REQ_CLEAR:      cmd_next.op = pmf_pkg::OP_CLEAR;
      pmf_pkg::REQ_FRAME: begin
        if (hdr == pmf_pkg::HDR_SUBSCRIBE) begin
          cmd_next.op = pmf_pkg::OP_SUBSCRIBE;
          cmd_next.id = opnd;
        end else if (hdr == pmf_pkg::HDR_UNSUBSCRIBE) begin
          cmd_next.op = pmf_pkg::OP_UNSUBSCRIBE;
          cmd_next.id = opnd;
        end else begin
          cmd_next.op = pmf_pkg::OP_DISPATCH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

[design/pmf_cmd_fifo.sv]
`default_nettype none

module pmf_cmd_fifo (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire pmf_pkg::cmd_t push_cmd,
  output logic           not_full,
  input  wire logic      pop,
  output pmf_pkg::cmd_t  head,
  output logic           not_empty
);

  pmf_pkg::cmd_t                 slots [pmf_pkg::FIFO_DEPTH];
  logic [pmf_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [pmf_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [pmf_pkg::FIFO_CW-1:0]   count;
  logic                          do_push;

  localparam logic [pmf_pkg::FIFO_AW-1:0] PTR_LAST =
    pmf_pkg::FIFO_AW'(pmf_pkg::FIFO_DEPTH - 1);
  localparam logic [pmf_pkg::FIFO_CW-1:0] COUNT_FULL =
    pmf_pkg::FIFO_CW'(pmf_pkg::FIFO_DEPTH);

  assign not_full  = count != COUNT_FULL;
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_push   = push && not_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("command queue popped while empty");
`endif

endmodule

`default_nettype wire

[design/pmf_back.sv]
`default_nettype none

module pmf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire pmf_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               init_busy,
  output logic               res_valid,
  input  wire logic          res_ready,
  output pmf_pkg::result_t   res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_WALK,
    S_WALK_END,
    S_ROW_WR,
    S_DISP,
    S_EMIT
  } state_t;

  state_t                         state;
  logic [pmf_pkg::ADDR_W-1:0]     idx;
  pmf_pkg::cmd_t                  cur;
  logic [pmf_pkg::ROW_W-1:0]      targets;
  logic [pmf_pkg::ROW_W-1:0]      present;
  logic [pmf_pkg::ROW_W-1:0]      rdata;

  logic [pmf_pkg::ROW_W-1:0]      rows [pmf_pkg::ROW_COUNT];

  logic [pmf_pkg::ADDR_W-1:0]     raddr;
  logic                           mem_we;
  logic [pmf_pkg::ADDR_W-1:0]     mem_waddr;
  logic [pmf_pkg::ROW_W-1:0]      mem_wdata;
  logic [pmf_pkg::ROW_W-1:0]      cur_bit;
  logic [pmf_pkg::ROW_W-1:0]      cmd_bit;
  logic [pmf_pkg::PORT_W-1:0]     low;
  logic [pmf_pkg::ROW_W-1:0]      low_bit;
  logic [pmf_pkg::ROW_W-1:0]      rest;
  logic                           out_free;
  logic                           emit;

  assign cur_bit  = pmf_pkg::ROW_W'(1) << cur.port;
  assign cmd_bit  = pmf_pkg::ROW_W'(1) << cmd.port;
  assign out_free = !res_valid || res_ready;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign raddr    = (state == S_WALK) ? idx : cmd.id;
  // load the next destination into the result register
  assign emit     = (state == S_EMIT) && (targets != '0) && out_free;

  // lowest pending destination
  always_comb begin
    low = '0;
    for (int i = pmf_pkg::PORT_LIMIT - 1; i >= 0; i--) begin
      if (targets[i]) begin
        low = pmf_pkg::PORT_W'(i);
      end
    end
  end
  assign low_bit = pmf_pkg::ROW_W'(1) << low;
  assign rest    = targets & ~low_bit;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_WALK: begin
        // write back the row read in the previous cycle
        mem_we    = idx != '0;
        mem_waddr = idx - 1'b1;
        mem_wdata = rdata & ~cur_bit;
      end
      S_WALK_END: begin
        mem_we    = 1'b1;
        mem_wdata = rdata & ~cur_bit;
      end
      S_ROW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur.id;
        mem_wdata = (cur.op == pmf_pkg::OP_SUBSCRIBE) ? (rdata | cur_bit)
                                                      : (rdata & ~cur_bit);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rows[mem_waddr] <= mem_wdata;
    end
    rdata <= rows[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      present   <= '0;
      init_busy <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            case (cmd.op)
              pmf_pkg::OP_CONNECT: begin
                present <= present | cmd_bit;
              end
              pmf_pkg::OP_DISCONNECT: begin
                present <= present & ~cmd_bit;
                idx     <= '0;
                state   <= S_WALK;
              end
              pmf_pkg::OP_CLEAR: begin
                present <= '0;
                idx     <= '0;
                state   <= S_CLEAR;
              end
              pmf_pkg::OP_SUBSCRIBE: begin
                present <= present | cmd_bit;
                state   <= S_ROW_WR;
              end
              pmf_pkg::OP_UNSUBSCRIBE: begin
                state <= S_ROW_WR;
              end
              pmf_pkg::OP_DISPATCH: begin
                if (cmd.id == pmf_pkg::ID_BROADCAST) begin
                  targets <= present & ~cmd_bit;
                  state   <= S_EMIT;
                end else begin
                  state <= S_DISP;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (idx == pmf_pkg::ADDR_MAX) begin
            init_busy <= 1'b0;
            state     <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_WALK: begin
          if (idx == pmf_pkg::ADDR_MAX) begin
            state <= S_WALK_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_WALK_END: begin
          state <= S_IDLE;
        end
        S_ROW_WR: begin
          state <= S_IDLE;
        end
        S_DISP: begin
          targets <= rdata & present & ~cur_bit;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (targets == '0) begin
            state <= S_IDLE;
          end else if (out_free) begin
            targets <= rest;
            if (rest == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.dest_port  <= low;
      res.from_port  <= cur.port;
      res.message_id <= cur.id;
      res.last       <= rest == '0;
    end
  end

`ifndef SYNTHESIS
  a_walk_port_gone: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ((present & cur_bit) == '0))
    else $error("port still present during its disconnect walk");

  a_sender_excluded: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.dest_port != res.from_port))
    else $error("frame routed back to its sender");

  a_no_pop_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !cmd_pop)
    else $error("command taken before the table clear finished");
`endif

endmodule

`default_nettype wire

[design/pubsub_multicast_filter_core.sv]
`default_nettype none

// Publish/subscribe multicast filter. Requests arrive on the s_ side: tuser
// carries the request kind (connect, disconnect, clear all, frame) and tdata
// the source port, header and operand words. A frame with header 0xFFFF
// subscribes the sender to the operand id (and connects it), 0xFFFE
// unsubscribes it, and any other header is dispatched: id 0 to every
// connected port, other ids to connected subscribers, never to the sender.
// One result per destination leaves on the m_ side in ascending port order,
// with tlast on the final one; a dispatch with no destination gives nothing.
// Requests from ports at or beyond the port count are dropped, except clear
// all. The table is a 65536 x 16 single-write, single-read memory. After
// reset a clearing pass writes every row, one a cycle; s_tready stays low
// until it is done. In the execution stage connect only updates the set of
// connected ports; subscribe and unsubscribe read then write the row;
// dispatch reads the row for a non-zero id, then gives one result per
// destination; clear all and disconnect sweep the whole table, bounded by
// the one memory write port. The front stage and a four-entry command queue
// keep accepting requests while the execution stage is busy. The result
// register hands on one result a cycle while m_tready stays high; a result
// left waiting holds the execution stage until it is taken.
module pubsub_multicast_filter_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [39:0]   s_tdata,   // source_port, header_word, operand_word, pad
  input  wire logic [1:0]    s_tuser,   // req_type
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [23:0]        m_tdata,   // dest_port, from_port, message_id
  output logic               m_tlast
);

  logic                  front_valid;
  pmf_pkg::cmd_t         front_cmd;
  logic                  fifo_not_full;
  pmf_pkg::cmd_t         fifo_head;
  logic                  fifo_not_empty;
  logic                  fifo_pop;
  logic                  init_busy;
  pmf_pkg::result_t      res;

  // accept and classify requests
  pmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .init_busy (init_busy),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (fifo_not_full)
  );

  // hold classified commands while the table is busy
  pmf_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_cmd  (front_cmd),
    .not_full  (fifo_not_full),
    .pop       (fifo_pop),
    .head      (fifo_head),
    .not_empty (fifo_not_empty)
  );

  // carry commands out against the table and emit destinations
  pmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (fifo_not_empty),
    .cmd       (fifo_head),
    .cmd_pop   (fifo_pop),
    .init_busy (init_busy),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {res.message_id, res.from_port, res.dest_port};
  assign m_tlast = res.last;

endmodule

`default_nettype wire

[verif/tb_pubsub_multicast_filter_core.sv]
`timescale 1ns / 1ps

module tb_pubsub_multicast_filter_core;

  localparam int CLK_HALF    = 2;
  localparam int RESET_LEN   = 5;
  // The longest quiet stretch in a correct run is the table sweeps queued
  // ahead of the last request, each of which walks the whole table, or
  // the clearing pass after reset.
  localparam int IDLE_LIMIT  = 2000000;
  localparam int HOLD_OFF    = 400;
  localparam int TAIL_CYCLES = 64;
  localparam int TOPIC_COUNT = 6;

  // Subscription table, connected ports and the deliveries still owed.
  class fanout_tracker;
    bit [pmf_pkg::ROW_W-1:0] rows [bit [pmf_pkg::ID_W-1:0]];
    bit [pmf_pkg::ROW_W-1:0] present;
    pmf_pkg::result_t        deliveries_due[$];
    int                      errors;

    function bit [pmf_pkg::ROW_W-1:0] row_at(bit [pmf_pkg::ID_W-1:0] id);
      return rows.exists(id) ? rows[id] : '0;
    endfunction

    function int pending();
      return deliveries_due.size();
    endfunction

    // Apply one accepted request and queue the deliveries it causes.
    function void note_request(logic [1:0] kind, logic [pmf_pkg::PORT_W-1:0] src,
                               logic [pmf_pkg::ID_W-1:0] hdr,
                               logic [pmf_pkg::ID_W-1:0] opnd);
      bit [pmf_pkg::ROW_W-1:0] port_bit;
      bit [pmf_pkg::ROW_W-1:0] targets;
      bit [pmf_pkg::ROW_W-1:0] remaining;
      pmf_pkg::result_t        item;
      if (kind == pmf_pkg::REQ_CLEAR) begin
        rows.delete();
        present = '0;
        return;
      end
      if (int'(src) >= pmf_pkg::PORT_LIMIT) return;
      port_bit = pmf_pkg::ROW_W'(1) << src;
      case (kind)
        pmf_pkg::REQ_CONNECT: begin
          present |= port_bit;
        end
        pmf_pkg::REQ_DISCONNECT: begin
          foreach (rows[i]) rows[i] &= ~port_bit;
          present &= ~port_bit;
        end
        default: begin
          if (hdr == pmf_pkg::HDR_SUBSCRIBE) begin
            present |= port_bit;
            rows[opnd] = row_at(opnd) | port_bit;
          end else if (hdr == pmf_pkg::HDR_UNSUBSCRIBE) begin
            rows[opnd] = row_at(opnd) & ~port_bit;
          end else begin
            targets = (hdr == pmf_pkg::ID_BROADCAST) ? present : (row_at(hdr) & present);
            targets &= ~port_bit;
            remaining = targets;
            for (int p = 0; p < pmf_pkg::PORT_LIMIT; p++) begin
              if (targets[p]) begin
                remaining[p]    = 1'b0;
                item.message_id = hdr;
                item.from_port  = src;
                item.dest_port  = pmf_pkg::PORT_W'(p);
                item.last       = (remaining == '0);
                deliveries_due.push_back(item);
              end
            end
          end
        end
      endcase
    endfunction

    // Compare one delivery with the oldest one owed.
    function void check_delivery(logic [pmf_pkg::PORT_W-1:0] dest,
                                 logic [pmf_pkg::PORT_W-1:0] from,
                                 logic [pmf_pkg::ID_W-1:0] id, logic last);
      pmf_pkg::result_t want;
      if (deliveries_due.size() == 0) begin
        $display("%0t: delivery with none owed: dest %0d from %0d id %h last %b",
                 $time, dest, from, id, last);
        errors++;
        return;
      end
      want = deliveries_due.pop_front();
      if (dest !== want.dest_port) begin
        $display("%0t: dest_port expected %0d got %0d", $time, want.dest_port, dest);
        errors++;
      end
      if (from !== want.from_port) begin
        $display("%0t: from_port expected %0d got %0d", $time, want.from_port, from);
        errors++;
      end
      if (id !== want.message_id) begin
        $display("%0t: message_id expected %h got %h", $time, want.message_id, id);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b got %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // source_port, header_word, operand_word, pad
  logic [1:0]  s_tuser  = '0;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // dest_port, from_port, message_id
  logic        m_tlast;

  fanout_tracker             hub;
  int                        idle_cycles  = 0;
  int                        sweeps_left  = 4;
  bit                        steady_feed  = 1'b0;
  bit                        hold_off_req = 1'b0;
  logic [pmf_pkg::ID_W-1:0]  topic_ids [TOPIC_COUNT];

  pubsub_multicast_filter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one request after an optional gap and hold it until accepted.
  // With no gap, tvalid simply stays high into the next request.
  task automatic issue_request(input logic [1:0] kind,
                               input logic [pmf_pkg::PORT_W-1:0] src,
                               input logic [pmf_pkg::ID_W-1:0] hdr,
                               input logic [pmf_pkg::ID_W-1:0] opnd);
    int gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, opnd, hdr, src};
    do @(posedge clk); while (!s_tready);
    hub.note_request(kind, src, hdr, opnd);
  endtask

  task automatic send_frame(input logic [pmf_pkg::PORT_W-1:0] src,
                            input logic [pmf_pkg::ID_W-1:0] hdr,
                            input logic [pmf_pkg::ID_W-1:0] opnd);
    issue_request(pmf_pkg::REQ_FRAME, src, hdr, opnd);
  endtask

  // Mostly well-formed traffic over a small pool of topics, with a little
  // noise and a bounded number of table sweeps, each of which is very slow.
  task automatic random_traffic(input int count);
    int                         roll;
    logic [pmf_pkg::PORT_W-1:0] src;
    logic [pmf_pkg::ID_W-1:0]   topic;
    repeat (count) begin
      roll  = $urandom_range(0, 99);
      src   = pmf_pkg::PORT_W'($urandom_range(0, 15));
      topic = topic_ids[$urandom_range(0, TOPIC_COUNT - 1)];
      if (roll < 3 && sweeps_left > 0) begin
        sweeps_left--;
        issue_request((roll < 2) ? pmf_pkg::REQ_DISCONNECT : pmf_pkg::REQ_CLEAR, src,
                      pmf_pkg::ID_W'($urandom), pmf_pkg::ID_W'($urandom));
      end else if (roll < 13) begin
        issue_request(pmf_pkg::REQ_CONNECT, src, pmf_pkg::ID_W'($urandom),
                      pmf_pkg::ID_W'($urandom));
      end else if (roll < 43) begin
        send_frame(src, pmf_pkg::HDR_SUBSCRIBE,
                   (roll < 40) ? topic : pmf_pkg::ID_W'($urandom));
      end else if (roll < 53) begin
        send_frame(src, pmf_pkg::HDR_UNSUBSCRIBE, topic);
      end else if (roll < 86) begin
        send_frame(src, topic, pmf_pkg::ID_W'($urandom));
      end else if (roll < 93) begin
        send_frame(src, pmf_pkg::ID_BROADCAST, pmf_pkg::ID_W'($urandom));
      end else begin
        send_frame(src, pmf_pkg::ID_W'($urandom), pmf_pkg::ID_W'($urandom));
      end
    end
  endtask

  // Receiver: random ready runs and stalls, plus one long hold-off on demand
  // so that results back up and the block stalls its input.
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Check deliveries and watch for a stuck block.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      hub.check_delivery(m_tdata[3:0], m_tdata[7:4], m_tdata[23:8], m_tlast);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    hub = new;
    topic_ids[0] = 16'h0001;
    topic_ids[1] = 16'hFFFD;
    topic_ids[2] = 16'h8000;
    for (int i = 3; i < TOPIC_COUNT; i++)
      topic_ids[i] = pmf_pkg::ID_W'($urandom_range(1, 16'hFFFD));

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: connects, subscribe at the id extremes, dispatch with the
    // sender excluded, unconnected senders, unsubscribe keeping the port
    // connected, no destination, disconnect and clear all.
    issue_request(pmf_pkg::REQ_CONNECT, 4'd0, 16'h0000, 16'h0000);
    issue_request(pmf_pkg::REQ_CONNECT, 4'd15, 16'hFFFF, 16'hFFFF);
    issue_request(pmf_pkg::REQ_CONNECT, 4'd0, 16'hA5A5, 16'h5A5A);   // already connected
    send_frame(4'd3, pmf_pkg::HDR_SUBSCRIBE, 16'hFFFF);              // also connects port 3
    send_frame(4'd15, pmf_pkg::HDR_SUBSCRIBE, 16'h0000);
    send_frame(4'd0, pmf_pkg::HDR_SUBSCRIBE, 16'h1234);
    send_frame(4'd7, pmf_pkg::HDR_SUBSCRIBE, 16'h1234);
    send_frame(4'd0, 16'h1234, 16'h0000);                            // sender skipped
    send_frame(4'd5, pmf_pkg::ID_BROADCAST, 16'hFFFF);               // unconnected sender
    send_frame(4'd9, 16'h1234, 16'hFFFF);
    send_frame(4'd7, pmf_pkg::HDR_UNSUBSCRIBE, 16'h1234);            // stays connected
    send_frame(4'd15, 16'h1234, 16'h0000);
    send_frame(4'd12, pmf_pkg::HDR_UNSUBSCRIBE, 16'h1234);           // never connected
    send_frame(4'd0, 16'hFFFD, 16'h0000);                            // nobody subscribed
    issue_request(pmf_pkg::REQ_DISCONNECT, 4'd3, 16'h0000, 16'hFFFF);
    issue_request(pmf_pkg::REQ_DISCONNECT, 4'd12, 16'hFFFF, 16'h0000); // not connected
    send_frame(4'd0, pmf_pkg::ID_BROADCAST, 16'h0000);
    send_frame(4'd3, pmf_pkg::ID_BROADCAST, 16'h0000);               // dropped sender
    issue_request(pmf_pkg::REQ_CLEAR, 4'd15, 16'hFFFF, 16'hFFFF);
    send_frame(4'd1, pmf_pkg::ID_BROADCAST, 16'h0000);               // nobody present
    send_frame(4'd0, 16'h1234, 16'h0000);
    send_frame(4'd9, pmf_pkg::HDR_SUBSCRIBE, 16'hFFFD);
    send_frame(4'd2, 16'hFFFD, 16'hFFFF);
    send_frame(4'd6, 16'h8000, 16'h7FFF);

    // Pressure: connect every port, then hold the receiver off while
    // full-fan-out broadcasts keep arriving back to back.
    steady_feed = 1'b1;
    for (int p = 0; p < 16; p++)
      issue_request(pmf_pkg::REQ_CONNECT, pmf_pkg::PORT_W'(p), pmf_pkg::ID_W'($urandom),
                    pmf_pkg::ID_W'($urandom));
    hold_off_req = 1'b1;
    repeat (12)
      send_frame(pmf_pkg::PORT_W'($urandom_range(0, 15)), pmf_pkg::ID_BROADCAST,
                 pmf_pkg::ID_W'($urandom));
    steady_feed = 1'b0;

    random_traffic(170);

    // Close with a dispatch that surely has destinations, so that its last
    // delivery proves every earlier request, sweeps included, is done.
    issue_request(pmf_pkg::REQ_CONNECT, 4'd0, 16'h0000, 16'h0000);
    issue_request(pmf_pkg::REQ_CONNECT, 4'd1, 16'h0000, 16'h0000);
    send_frame(4'd15, pmf_pkg::ID_BROADCAST, 16'h0000);
    s_tvalid <= 1'b0;

    while (hub.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (hub.errors == 0 && hub.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
